// ===== hw/rtl/dsf3d_pkg.sv =====
// ----------------------------------------------------------------------------
// dsf3d_pkg
// Shared types and constants for the damped spring follower.
// ----------------------------------------------------------------------------
package dsf3d_pkg;

    localparam int REG_IDX_W = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_STIFFNESS = 3'd0,
        REG_DAMPING   = 3'd1,
        REG_AMPLITUDE = 3'd2,
        REG_TIME_STEP = 3'd3,
        REG_FORCE_X   = 3'd4,
        REG_FORCE_Y   = 3'd5,
        REG_FORCE_Z   = 3'd6,
        REG_UNUSED    = 3'd7
    } reg_idx_t;

    localparam logic CMD_STEP   = 1'b0;
    localparam logic CMD_REINIT = 1'b1;

    typedef logic signed [31:0] q_t;

    // Divider interface
    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
    } div_rsp_t;

    function automatic q_t sat32(input logic signed [79:0] x);
        if (x > 80'sd2147483647)
            return 32'sh7fffffff;
        else if (x < -80'sd2147483648)
            return 32'sh80000000;
        else
            return x[31:0];
    endfunction

endpackage

// ===== hw/rtl/dsf3d_div.sv =====
// ----------------------------------------------------------------------------
// dsf3d_div
// Unsigned 64 by 64 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dsf3d_div
(
    input  logic                clk,
    input  logic                rst_n,
    input  dsf3d_pkg::div_req_t req,
    output dsf3d_pkg::div_rsp_t rsp
);
    import dsf3d_pkg::*;

    logic [63:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [63:0] den_reg, den_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [64:0] trial;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[63]} - {1'b0, den_reg};
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.num;
            den_next  = req.den;
            cnt_next  = 7'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[64])
            begin
                rem_next = trial[63:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[62:0], quo_reg[63]};
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

// ===== hw/rtl/damped_spring_follower_3d_top.sv =====
// ----------------------------------------------------------------------------
// damped_spring_follower_3d_top
// 3D damped spring follower: one shared multiplier and a shared divider.
// ----------------------------------------------------------------------------
// Sequence: a reinitialize request shows its result in the cycle after acceptance;
// a step request runs the pull, damp, force, velocity, position, square and next
// states for each axis, then one scale divide when pulled back, then three velocity
// divides, all on the shared serial divider.
// Throughput: one request at a time; in_stall is high until the result is taken.
// Reset: position and velocity clear to zero, registers take reset values.
module damped_spring_follower_3d_top
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [dsf3d_pkg::REG_IDX_W-1:0]    cfg_index,
    input  logic [31:0]                        cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               command,
    input  logic signed [31:0]                 goal_x,
    input  logic signed [31:0]                 goal_y,
    input  logic signed [31:0]                 goal_z,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [31:0]                 pos_x,
    output logic signed [31:0]                 pos_y,
    output logic signed [31:0]                 pos_z,
    output logic signed [31:0]                 vel_x,
    output logic signed [31:0]                 vel_y,
    output logic signed [31:0]                 vel_z
);
    import dsf3d_pkg::*;

    localparam logic signed [79:0] ONE_Q = 80'sd1 <<< FRAC_BITS;
    localparam logic [16:0]        TENTH = 17'((ONE_Q + 5) / 10);

    typedef enum logic [3:0] {
        S_IDLE, S_PULL, S_DAMP, S_FDT, S_V1, S_POS, S_SQ, S_NEXT,
        S_SDIV, S_SWAIT, S_SCALE, S_VDIV, S_VWAIT, S_OUT
    } state_t;

    state_t state_reg;
    logic [1:0] ax_reg;

    logic [16:0] stiff_reg, damp_reg;
    logic [30:0] amp_reg, dt_cfg_reg;
    q_t          force_reg [3];
    q_t          pos_reg [3], vel_reg [3];
    q_t          goal_reg [3], p1_reg [3];
    logic signed [33:0] dx_reg [3];
    q_t          t_reg;      // running intermediate
    q_t          fdt_reg;
    logic [63:0] d2_reg;
    logic        huge_reg;
    logic [63:0] s_reg;
    logic        out_valid_reg;

    // shared multiplier
    logic signed [33:0] ma, mb;
    logic signed [67:0] mp;
    logic signed [79:0]  mfl;
    assign mp  = ma * mb;
    assign mfl = 80'(mp >>> FRAC_BITS);

    div_req_t dreq;
    div_rsp_t drsp;
    dsf3d_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    logic [63:0] dt;
    assign dt = (dt_cfg_reg == '0) ? 64'd1 : {33'd0, dt_cfg_reg};

    logic signed [79:0] keep;
    assign keep = ONE_Q - 80'(damp_reg);

    logic signed [33:0] dxa;
    logic [33:0] mag;
    logic [63:0] sq, d2sum;
    logic        ovf;
    logic signed [63:0] num;
    logic        neg;
    logic [63:0] unum, q;
    logic signed [79:0] sq_sgn;

    always_comb
    begin
        ma = '0;
        mb = '0;
        unique case (state_reg)
            S_PULL:  begin ma = 34'(goal_reg[ax_reg]) - 34'(pos_reg[ax_reg]);
                           mb = 34'(stiff_reg); end
            S_DAMP:  begin ma = 34'(t_reg); mb = 34'(keep); end
            S_FDT:   begin ma = 34'(force_reg[ax_reg]); mb = 34'(dt); end
            S_POS:   begin ma = 34'(t_reg); mb = 34'(dt); end
            S_NEXT:  begin ma = dx_reg[ax_reg]; mb = dx_reg[ax_reg]; end
            S_SCALE: begin ma = dx_reg[ax_reg]; mb = 34'(s_reg); end
            default: ;
        endcase
        dxa    = 34'(p1_reg[ax_reg]) - 34'(goal_reg[ax_reg]);
        mag    = dxa[33] ? 34'(-dxa) : dxa;
        sq_sgn = mfl;
        sq     = sq_sgn[63:0];
        d2sum  = d2_reg + sq;
        ovf    = d2sum < d2_reg;
        num    = (64'(p1_reg[ax_reg]) - 64'(pos_reg[ax_reg])) <<< FRAC_BITS;
        neg    = num[63];
        unum   = neg ? -num : num;
        q      = drsp.quo;
        dreq.start = 1'b0;
        dreq.num   = '0;
        dreq.den   = dt;
        if (state_reg == S_SDIV)
        begin
            dreq.start = 1'b1;
            dreq.num   = {33'd0, amp_reg} << FRAC_BITS;
            dreq.den   = d2_reg;
        end
        else if (state_reg == S_VDIV)
        begin
            dreq.start = 1'b1;
            dreq.num   = unum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ax_reg        <= '0;
            out_valid_reg <= 1'b0;
            stiff_reg     <= TENTH;
            damp_reg      <= TENTH;
            amp_reg       <= 31'(ONE_Q);
            dt_cfg_reg    <= 31'(TENTH);
            t_reg         <= '0;
            fdt_reg       <= '0;
            d2_reg        <= '0;
            huge_reg      <= 1'b0;
            s_reg         <= '0;
            for (int i = 0; i < 3; i++)
            begin
                force_reg[i] <= '0;
                pos_reg[i]   <= '0;
                vel_reg[i]   <= '0;
                goal_reg[i]  <= '0;
                p1_reg[i]    <= '0;
                dx_reg[i]    <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (reg_idx_t'(cfg_index))
                    REG_STIFFNESS: stiff_reg    <= cfg_data[16:0];
                    REG_DAMPING:   damp_reg     <= cfg_data[16:0];
                    REG_AMPLITUDE: amp_reg      <= cfg_data[30:0];
                    REG_TIME_STEP: dt_cfg_reg   <= cfg_data[30:0];
                    REG_FORCE_X:   force_reg[0] <= cfg_data;
                    REG_FORCE_Y:   force_reg[1] <= cfg_data;
                    REG_FORCE_Z:   force_reg[2] <= cfg_data;
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                    if (in_valid)
                    begin
                        goal_reg[0] <= goal_x;
                        goal_reg[1] <= goal_y;
                        goal_reg[2] <= goal_z;
                        ax_reg      <= '0;
                        d2_reg      <= '0;
                        huge_reg    <= 1'b0;
                        if (command == CMD_REINIT)
                        begin
                            pos_reg[0] <= goal_x;
                            pos_reg[1] <= goal_y;
                            pos_reg[2] <= goal_z;
                            for (int i = 0; i < 3; i++) vel_reg[i] <= '0;
                            state_reg <= S_OUT;
                            out_valid_reg <= 1'b1;
                        end
                        else
                            state_reg <= S_PULL;
                    end
                S_PULL:
                begin
                    t_reg <= sat32(80'(vel_reg[ax_reg]) + 80'(sat32(mfl)));
                    state_reg <= S_DAMP;
                end
                S_DAMP:
                begin
                    t_reg <= sat32(mfl);
                    state_reg <= S_FDT;
                end
                S_FDT:
                begin
                    fdt_reg   <= sat32(mfl);
                    state_reg <= S_V1;
                end
                S_V1:
                begin
                    t_reg <= sat32(80'(t_reg) + 80'(fdt_reg));
                    state_reg <= S_POS;
                end
                S_POS:
                begin
                    p1_reg[ax_reg] <= sat32(80'(pos_reg[ax_reg]) + mfl);
                    state_reg <= S_SQ;
                end
                S_SQ:
                begin
                    // this state latches dx; the multiplier reads it next, in S_NEXT
                    dx_reg[ax_reg] <= dxa;
                    if (mag[33:32] != 2'b00)
                        huge_reg <= 1'b1;
                    state_reg <= S_NEXT;
                end
                S_NEXT:
                begin
                    if (!huge_reg && dx_reg[ax_reg] == dxa)
                        d2_reg <= ovf ? '1 : d2sum;
                    if (ax_reg == 2'd2)
                    begin
                        ax_reg    <= '0;
                        state_reg <= S_SDIV;
                    end
                    else
                    begin
                        ax_reg    <= ax_reg + 2'd1;
                        state_reg <= S_PULL;
                    end
                end
                S_SDIV:
                begin
                    if (huge_reg)
                        d2_reg <= '1;
                    if (huge_reg || d2_reg > 64'(amp_reg))
                    begin
                        if (huge_reg) state_reg <= S_SDIV;
                        else          state_reg <= S_SWAIT;
                        huge_reg <= 1'b0;
                    end
                    else
                        state_reg <= S_VDIV;
                end
                S_SWAIT:
                    if (drsp.done)
                    begin
                        s_reg     <= drsp.quo;
                        state_reg <= S_SCALE;
                    end
                S_SCALE:
                begin
                    p1_reg[ax_reg] <= sat32(80'(goal_reg[ax_reg]) + mfl);
                    if (ax_reg == 2'd2)
                    begin
                        ax_reg    <= '0;
                        state_reg <= S_VDIV;
                    end
                    else
                        ax_reg <= ax_reg + 2'd1;
                end
                S_VDIV:
                    state_reg <= S_VWAIT;
                S_VWAIT:
                    if (drsp.done)
                    begin
                        vel_reg[ax_reg] <= neg ? sat32(-80'(q)) : sat32(80'(q));
                        pos_reg[ax_reg] <= p1_reg[ax_reg];
                        if (ax_reg == 2'd2)
                        begin
                            state_reg     <= S_OUT;
                            out_valid_reg <= 1'b1;
                        end
                        else
                        begin
                            ax_reg    <= ax_reg + 2'd1;
                            state_reg <= S_VDIV;
                        end
                    end
                S_OUT:
                    if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign pos_x = pos_reg[0];
    assign pos_y = pos_reg[1];
    assign pos_z = pos_reg[2];
    assign vel_x = vel_reg[0];
    assign vel_y = vel_reg[1];
    assign vel_z = vel_reg[2];

    a_outv_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> state_reg == S_OUT)
        else $error("result shown outside output state");
    a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("request taken while result pending");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid && $stable(pos_x) && $stable(vel_x))
        else $error("pending result changed");

endmodule
